/* hw/rtl/bpfa_pkg.sv */
// Package for the bitmap page frame allocator.
// Holds command and status codes, sequencer types and saturating counter helpers.
// No dependencies.
`default_nettype none

package bpfa_pkg;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_RESERVE = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_FINISH  = 3'd4;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REFUSE = 2'd1;
  localparam logic [1:0] STAT_IGNORE = 2'd2;

  localparam int unsigned CNT_W     = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_RD,
    ST_LD,
    ST_BIT,
    ST_WB,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MD_RESERVE,
    MD_RELEASE,
    MD_SCAN,
    MD_MARK,
    MD_FREE,
    MD_FINISH
  } mode_e;

  typedef struct packed {
    logic we;
    logic re;
  } map_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc1(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec1(input logic [CNT_W-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bpfa_map.sv */
// Used-bit map storage: one 32-bit word per 32 page frames.
// One write port and one read port with registered read data; uses bpfa_pkg.
`default_nettype none

module bpfa_map #(
  parameter int unsigned WORDS = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire                   clk_i,
  input  wire bpfa_pkg::map_ctrl_t ctrl_i,
  input  wire  [AW-1:0]         waddr_i,
  input  wire  [31:0]           wdata_i,
  input  wire  [AW-1:0]         raddr_i,
  output logic [31:0]           rdata_o
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator: command sequencer and counters.
// Depends on bpfa_pkg and bpfa_map.
`default_nettype none

// After reset the block first sweeps the map to all-used, one word per cycle, writing
// (PAGE_CAPACITY+31)/32 words (2048 by default) while in_ready_o stays low. Each command then
// runs alone through a small sequencer that walks the map one page frame per cycle over a
// buffered 32-bit word, pausing whenever a word is fetched or written back. A word is fetched
// through a read and a load state, and written back in a write-back state once it is done,
// except in the search pass and for an ignored free. An allocate first searches for a run of
// free frames, from the hint onwards and then from frame 1, and then marks that run as used.
// One result follows each command; a new command may be accepted while the previous result
// still waits on the output.
module bitmap_page_frame_allocator #(
  parameter int unsigned PAGE_CAPACITY = 65536,
  parameter int unsigned PAGE_SHIFT    = 12
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [16:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  command_i,
  input  wire  [16:0] page_count_i,
  input  wire  [31:0] free_address_i,
  input  wire  [31:0] range_start_i,
  input  wire  [32:0] range_end_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [27:0] page_address_o,
  output logic [16:0] free_count_o,
  output logic [16:0] used_count_o
);

  localparam int unsigned PW    = ($clog2(PAGE_CAPACITY + 1) < 6) ? 6
                                                                  : $clog2(PAGE_CAPACITY + 1);
  localparam int unsigned WORDS = (PAGE_CAPACITY + 31) / 32;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = ((PW > 17) ? PW : 17) + 1;

  bpfa_pkg::state_e        state_q, state_d;
  bpfa_pkg::mode_e         mode_q, mode_d;
  logic [PW-1:0]           cur_q, cur_d, end_q, end_d, start_q, start_d, hint_q, hint_d;
  logic [16:0]             run_q, run_d, cnt_q, cnt_d;
  logic [16:0]             free_q, free_d, used_q, used_d, total_q;
  logic                    pass_q, pass_d, ready_q, ready_d;
  logic [1:0]              stat_q, stat_d;
  logic [27:0]             addr_q, addr_d;
  logic [31:0]             wbuf_q, wbuf_d;
  logic [WAW-1:0]          wa_q, wa_d, clr_q, clr_d;
  logic                    oval_q, oval_d;
  logic [1:0]              ostat_q;
  logic [27:0]             oaddr_q;
  logic [16:0]             ofree_q, oused_q;

  bpfa_pkg::map_ctrl_t     map_ctrl;
  logic [WAW-1:0]          map_waddr, map_raddr;
  logic [31:0]             map_wdata, map_rdata;

  bpfa_map #(
    .WORDS (WORDS),
    .AW    (WAW)
  ) u_map (
    .clk_i   (clk_i),
    .ctrl_i  (map_ctrl),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  function automatic logic [PW-1:0] clip(input logic [33:0] v);
    return (v > 34'(PAGE_CAPACITY)) ? PW'(PAGE_CAPACITY) : PW'(v);
  endfunction

  // Address arithmetic for range and free commands, and search pass bounds and bit-walk helpers.
  logic [33:0]   rs_ext, re_ext, ps_m1, rel_re, fpage;
  logic [PW-1:0] rsv_sp, rsv_ep, rel_sp_raw, rel_sp, rel_ep;
  logic [PW-1:0] eff, last_pg, start_h, pass_b, pass_e;
  logic          pass_ok, cur_bit, free_bad;
  logic [PW-1:0] cur_n, found_s;
  logic [PW+31:0] addr_full;

  always_comb begin
    rs_ext     = {2'b00, range_start_i};
    re_ext     = {1'b0, range_end_i};
    ps_m1      = (34'd1 << PAGE_SHIFT) - 34'd1;
    rsv_sp     = clip(rs_ext >> PAGE_SHIFT);
    rsv_ep     = clip((re_ext + ps_m1) >> PAGE_SHIFT);
    rel_re     = (re_ext > 34'h1_0000_0000) ? 34'h1_0000_0000 : re_ext;
    rel_sp_raw = clip((rs_ext + ps_m1) >> PAGE_SHIFT);
    rel_sp     = (rel_sp_raw == '0) ? PW'(1) : rel_sp_raw;
    rel_ep     = clip(rel_re >> PAGE_SHIFT);
    fpage      = {2'b00, free_address_i} >> PAGE_SHIFT;

    eff      = (34'(total_q) > 34'(PAGE_CAPACITY)) ? PW'(PAGE_CAPACITY) : PW'(total_q);
    last_pg  = (eff == '0) ? '0 : eff - 1'b1;
    free_bad = !ready_q || (free_address_i == '0) ||
               (({2'b00, free_address_i} & ps_m1) != '0) ||
               (fpage == '0) || (fpage >= 34'(eff));

    start_h = (hint_q == '0) ? PW'(1) : hint_q;
    pass_b  = pass_q ? PW'(1) : start_h;
    pass_e  = pass_q ? ((start_h < last_pg) ? start_h : last_pg) : last_pg;
    pass_ok = (pass_e > pass_b) && (CW'(cnt_q) + CW'(pass_b) <= CW'(pass_e) + CW'(1));

    cur_bit   = wbuf_q[cur_q[4:0]];
    cur_n     = cur_q + 1'b1;
    found_s   = PW'(CW'(cur_q) - CW'(cnt_q) + CW'(1));
    addr_full = {32'b0, start_q} << PAGE_SHIFT;
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    cur_d    = cur_q;
    end_d    = end_q;
    start_d  = start_q;
    hint_d   = hint_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    free_d   = free_q;
    used_d   = used_q;
    pass_d   = pass_q;
    ready_d  = ready_q;
    stat_d   = stat_q;
    addr_d   = addr_q;
    wbuf_d   = wbuf_q;
    wa_d     = wa_q;
    clr_d    = clr_q;
    oval_d   = oval_q && !out_ready_i;
    map_ctrl  = '0;
    map_waddr = wa_q;
    map_wdata = wbuf_q;
    map_raddr = WAW'(cur_q[PW-1:5]);
    in_ready_o = (state_q == bpfa_pkg::ST_IDLE);

    unique case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        map_ctrl.we = 1'b1;
        map_waddr   = clr_q;
        map_wdata   = '1;
        clr_d       = clr_q + 1'b1;
        if (clr_q == WAW'(WORDS - 1)) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      bpfa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          stat_d  = bpfa_pkg::STAT_OK;
          addr_d  = '0;
          state_d = bpfa_pkg::ST_DONE;
          cnt_d   = page_count_i;
          case (command_i)
            bpfa_pkg::CMD_ALLOC: begin
              if (!ready_q || page_count_i == '0 || page_count_i > free_q) begin
                stat_d = bpfa_pkg::STAT_REFUSE;
              end else begin
                mode_d  = bpfa_pkg::MD_SCAN;
                pass_d  = 1'b0;
                state_d = bpfa_pkg::ST_PASS;
              end
            end
            bpfa_pkg::CMD_FREE: begin
              if (free_bad) begin
                stat_d = bpfa_pkg::STAT_IGNORE;
              end else begin
                mode_d  = bpfa_pkg::MD_FREE;
                cur_d   = PW'(fpage);
                end_d   = PW'(fpage) + 1'b1;
                state_d = bpfa_pkg::ST_RD;
              end
            end
            bpfa_pkg::CMD_RESERVE: begin
              if (rsv_sp < rsv_ep) begin
                mode_d  = bpfa_pkg::MD_RESERVE;
                cur_d   = rsv_sp;
                end_d   = rsv_ep;
                state_d = bpfa_pkg::ST_RD;
              end
            end
            bpfa_pkg::CMD_RELEASE: begin
              if (rel_sp < rel_ep) begin
                mode_d  = bpfa_pkg::MD_RELEASE;
                cur_d   = rel_sp;
                end_d   = rel_ep;
                state_d = bpfa_pkg::ST_RD;
              end
            end
            bpfa_pkg::CMD_FINISH: begin
              mode_d  = bpfa_pkg::MD_FINISH;
              cur_d   = '0;
              end_d   = PW'(1);
              state_d = bpfa_pkg::ST_RD;
            end
            default: begin
              stat_d = bpfa_pkg::STAT_IGNORE;
            end
          endcase
        end
      end
      bpfa_pkg::ST_PASS: begin
        if (pass_ok) begin
          cur_d   = pass_b;
          end_d   = pass_e;
          run_d   = '0;
          state_d = bpfa_pkg::ST_RD;
        end else if (!pass_q) begin
          pass_d = 1'b1;
        end else begin
          stat_d  = bpfa_pkg::STAT_REFUSE;
          state_d = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_RD: begin
        map_ctrl.re = 1'b1;
        wa_d        = WAW'(cur_q[PW-1:5]);
        state_d     = bpfa_pkg::ST_LD;
      end
      bpfa_pkg::ST_LD: begin
        wbuf_d  = map_rdata;
        state_d = bpfa_pkg::ST_BIT;
      end
      bpfa_pkg::ST_BIT: begin
        if (mode_q == bpfa_pkg::MD_SCAN) begin
          // The search pass leaves the word untouched, so no write-back is needed.
          if (!cur_bit && (run_q + 1'b1 == cnt_q)) begin
            start_d = found_s;
            cur_d   = found_s;
            end_d   = cur_n;
            mode_d  = bpfa_pkg::MD_MARK;
            state_d = bpfa_pkg::ST_RD;
          end else begin
            run_d = cur_bit ? '0 : run_q + 1'b1;
            if (cur_q == end_q) begin
              if (!pass_q) begin
                pass_d  = 1'b1;
                state_d = bpfa_pkg::ST_PASS;
              end else begin
                stat_d  = bpfa_pkg::STAT_REFUSE;
                state_d = bpfa_pkg::ST_DONE;
              end
            end else begin
              cur_d   = cur_n;
              state_d = (cur_n[4:0] == '0) ? bpfa_pkg::ST_RD : bpfa_pkg::ST_BIT;
            end
          end
        end else if (mode_q == bpfa_pkg::MD_FREE && !cur_bit) begin
          stat_d  = bpfa_pkg::STAT_IGNORE;
          state_d = bpfa_pkg::ST_DONE;
        end else begin
          case (mode_q) inside
            bpfa_pkg::MD_RESERVE, bpfa_pkg::MD_MARK: begin
              if (!cur_bit) begin
                wbuf_d[cur_q[4:0]] = 1'b1;
                free_d = bpfa_pkg::sat_dec1(free_q);
                used_d = bpfa_pkg::sat_inc1(used_q);
              end
            end
            bpfa_pkg::MD_RELEASE, bpfa_pkg::MD_FREE: begin
              if (cur_bit) begin
                wbuf_d[cur_q[4:0]] = 1'b0;
                free_d = bpfa_pkg::sat_inc1(free_q);
                used_d = bpfa_pkg::sat_dec1(used_q);
              end
              if (mode_q == bpfa_pkg::MD_FREE && cur_q < hint_q) begin
                hint_d = cur_q;
              end
            end
            default: begin
              wbuf_d[0] = 1'b1;
              used_d    = (CW'(eff) >= CW'(free_q)) ? 17'(CW'(eff) - CW'(free_q)) : '0;
              hint_d    = PW'(1);
              ready_d   = 1'b1;
            end
          endcase
          cur_d = cur_n;
          if (cur_n == end_q || cur_n[4:0] == '0) begin
            state_d = bpfa_pkg::ST_WB;
          end
        end
      end
      bpfa_pkg::ST_WB: begin
        map_ctrl.we = 1'b1;
        if (cur_q == end_q) begin
          state_d = bpfa_pkg::ST_DONE;
          if (mode_q == bpfa_pkg::MD_MARK) begin
            hint_d = end_q;
            addr_d = 28'(addr_full);
          end
        end else begin
          state_d = bpfa_pkg::ST_RD;
        end
      end
      bpfa_pkg::ST_DONE: begin
        if (!oval_q || out_ready_i) begin
          oval_d  = 1'b1;
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfa_pkg::ST_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      used_q  <= 17'(PAGE_CAPACITY > 131071 ? 131071 : PAGE_CAPACITY);
      hint_q  <= PW'(1);
      ready_q <= 1'b0;
      total_q <= 17'h10000;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      used_q  <= used_d;
      hint_q  <= hint_d;
      ready_q <= ready_d;
      oval_q  <= oval_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    cur_q   <= cur_d;
    end_q   <= end_d;
    start_q <= start_d;
    run_q   <= run_d;
    cnt_q   <= cnt_d;
    pass_q  <= pass_d;
    stat_q  <= stat_d;
    addr_q  <= addr_d;
    wbuf_q  <= wbuf_d;
    wa_q    <= wa_d;
    if (state_q == bpfa_pkg::ST_DONE && (!oval_q || out_ready_i)) begin
      ostat_q <= stat_q;
      oaddr_q <= addr_q;
      ofree_q <= free_q;
      oused_q <= used_q;
    end
  end

  assign out_valid_o    = oval_q;
  assign status_o       = ostat_q;
  assign page_address_o = oaddr_q;
  assign free_count_o   = ofree_q;
  assign used_count_o   = oused_q;

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpfa_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("command accepted during map clear");

  a_hint_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q != '0)
    else $error("search hint reached frame 0");

  a_run_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpfa_pkg::ST_BIT && mode_q == bpfa_pkg::MD_SCAN) |-> (run_q < cnt_q))
    else $error("free run counter passed the requested count");

endmodule

`default_nettype wire
